>>> hw/rtl/mhwf_pkg.sv
`default_nettype none
package mhwf_pkg;

  localparam int HEAP_ENTRIES = 64;
  localparam int HEADER_BYTES = 8;
  localparam int ADDR_BITS    = 20;

  localparam int IDX_W   = $clog2(HEAP_ENTRIES);
  localparam int CNT_W   = IDX_W + 1;
  localparam int BYTE_W  = 21;
  localparam int ALIGN_W = 13;
  // Header plus request, before rounding.
  localparam int NEED_W  = BYTE_W + 1;
  // Rounded block size.
  localparam int RND_W   = NEED_W + 1;

  localparam logic [BYTE_W-1:0] POOL_RESET = BYTE_W'(65536);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RESET = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NO_FIT = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV,
    ST_FIT,
    ST_LAST,
    ST_SDL,
    ST_SDLW,
    ST_SDR,
    ST_SPLIT,
    ST_SU,
    ST_SUW,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] off;
    logic [BYTE_W-1:0]    bytes;
  } entry_t;

endpackage
`default_nettype wire

>>> hw/rtl/max_heap_worst_fit_allocator.sv
// Worst-fit allocator over one byte pool, with free blocks kept in a binary
// max-heap in a single-port-read RAM. Raise start while busy is low to hand
// in an item; the result appears for exactly one cycle with done high and
// cannot be stalled. An allocate runs the bit-serial alignment remainder,
// then the sift-down after the root is taken and the sift-up of a split
// tail, in a heap of up to 64 entries. A free climbs the heap level by level;
// reset-pool and the unused opcode keep busy high for one cycle. The RAM read
// port, one address per cycle, sets the heap walk rate. After reset the block
// seeds the root entry before taking items. pool_bytes takes effect at the
// next reset-pool operation.
`default_nettype none
module max_heap_worst_fit_allocator import mhwf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           opcode,
  input  wire logic [BYTE_W-1:0]    request_size,
  input  wire logic [ALIGN_W-1:0]   alignment,
  input  wire logic [ADDR_BITS-1:0] block_address,
  input  wire logic [BYTE_W-1:0]    freed_size,
  output logic                      done,
  output logic [1:0]                status,
  output logic [ADDR_BITS-1:0]      payload_address,
  output logic [BYTE_W-1:0]         granted_size,
  output logic [BYTE_W-1:0]         used_bytes,
  output logic [BYTE_W-1:0]         peak_bytes,
  output logic [CNT_W-1:0]          free_blocks,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [BYTE_W-1:0] used, used_next, peak, peak_next, pool;
  logic [IDX_W-1:0] idx, idx_next;
  entry_t mov, mov_next, root, root_next, lft, lft_next;
  logic [RND_W-1:0] need, need_next;
  logic [ALIGN_W-1:0] algn, algn_next;
  status_t st, st_next;
  logic [ADDR_BITS-1:0] pay, pay_next;
  logic [BYTE_W-1:0] grant, grant_next;

  logic ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t ram_wdata, rd;
  logic [$bits(entry_t)-1:0] rd_raw;

  logic rem_start, rem_done;
  logic [ALIGN_W-1:0] rem;

  logic [CNT_W:0] lchild, rchild;
  logic [IDX_W-1:0] parent;
  logic [RND_W:0] split_lim;
  logic split;
  logic [BYTE_W-1:0] gb;
  logic [BYTE_W:0] used_sum;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32 - BYTE_W){1'b0}}, pool};

  always_ff @(posedge clk) begin
    if (rst) begin
      pool <= POOL_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      pool <= pwdata[BYTE_W-1:0];
    end
  end

  mhwf_ram #(.WIDTH($bits(entry_t)), .DEPTH(HEAP_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_raw)
  );
  assign rd = entry_t'(rd_raw);

  mhwf_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (NEED_W'(HEADER_BYTES) + NEED_W'(request_size)),
    .divisor  (alignment == '0 ? ALIGN_W'(1) : alignment),
    .done     (rem_done),
    .rem      (rem)
  );

  // Heap index arithmetic.
  assign lchild    = {idx, 1'b1} + (CNT_W + 1)'(0);
  assign rchild    = lchild + (CNT_W + 1)'(1);
  assign parent    = IDX_W'((idx - IDX_W'(1)) >> 1);
  assign split_lim = (RND_W + 1)'(need) + (RND_W + 1)'(HEADER_BYTES);
  assign split     = (RND_W + 1)'(root.bytes) > split_lim;
  assign gb        = split ? need[BYTE_W-1:0] : root.bytes;
  assign used_sum  = {1'b0, used} + {1'b0, gb};

  // Outputs.
  assign busy            = (state != ST_IDLE);
  assign done            = (state == ST_DONE);
  assign status          = st;
  assign payload_address = pay;
  assign granted_size    = grant;
  assign used_bytes      = used;
  assign peak_bytes      = peak;
  assign free_blocks     = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      cnt   <= CNT_W'(1);
      used  <= '0;
      peak  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      used  <= used_next;
      peak  <= peak_next;
    end
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    mov   <= mov_next;
    root  <= root_next;
    lft   <= lft_next;
    need  <= need_next;
    algn  <= algn_next;
    st    <= st_next;
    pay   <= pay_next;
    grant <= grant_next;
  end

  // Sequencer.
  always_comb begin
    entry_t best;
    logic   best_self;
    logic [IDX_W-1:0] best_idx;

    state_next = state;
    cnt_next   = cnt;
    used_next  = used;
    peak_next  = peak;
    idx_next   = idx;
    mov_next   = mov;
    root_next  = root;
    lft_next   = lft;
    need_next  = need;
    algn_next  = algn;
    st_next    = st;
    pay_next   = pay;
    grant_next = grant;
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wdata  = mov;
    ram_raddr  = '0;
    rem_start  = 1'b0;
    best       = mov;
    best_self  = 1'b1;
    best_idx   = idx;

    // Pick the largest of the moving entry and its children.
    if (state == ST_SDLW || state == ST_SDR) begin
      if (mov.bytes < ((state == ST_SDR) ? lft.bytes : rd.bytes)) begin
        best      = (state == ST_SDR) ? lft : rd;
        best_self = 1'b0;
        best_idx  = lchild[IDX_W-1:0];
      end
      if (state == ST_SDR && best.bytes < rd.bytes) begin
        best      = rd;
        best_self = 1'b0;
        best_idx  = rchild[IDX_W-1:0];
      end
    end

    case (state)
      ST_INIT: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = '{off: '0, bytes: POOL_RESET};
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          st_next    = STAT_OK;
          pay_next   = '0;
          grant_next = '0;
          case (opcode_t'(opcode))
            OP_ALLOC: begin
              rem_start  = 1'b1;
              need_next  = RND_W'(HEADER_BYTES) + RND_W'(request_size);
              algn_next  = (alignment == '0) ? ALIGN_W'(1) : alignment;
              state_next = ST_DIV;
            end
            OP_FREE: begin
              if (cnt >= CNT_W'(HEAP_ENTRIES)) begin
                st_next    = STAT_FULL;
                state_next = ST_DONE;
              end else begin
                mov_next.off   = block_address - ADDR_BITS'(HEADER_BYTES);
                mov_next.bytes = freed_size;
                idx_next       = cnt[IDX_W-1:0];
                cnt_next       = cnt + CNT_W'(1);
                used_next      = (freed_size > used) ? '0 : used - freed_size;
                state_next     = ST_SU;
              end
            end
            OP_RESET: begin
              ram_we     = 1'b1;
              ram_waddr  = '0;
              ram_wdata  = '{off: '0, bytes: pool};
              cnt_next   = CNT_W'(1);
              used_next  = '0;
              peak_next  = '0;
              state_next = ST_DONE;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      // Round up to the alignment once the remainder is ready; fetch the root.
      ST_DIV: begin
        if (rem_done) begin
          if (rem != '0) begin
            need_next = need + RND_W'(algn - rem);
          end
          ram_raddr  = '0;
          state_next = ST_FIT;
        end
      end
      ST_FIT: begin
        if (cnt == '0 || need > RND_W'(rd.bytes)) begin
          st_next    = STAT_NO_FIT;
          state_next = ST_DONE;
        end else begin
          root_next = rd;
          cnt_next  = cnt - CNT_W'(1);
          if (cnt != CNT_W'(1)) begin
            ram_raddr  = IDX_W'(cnt - CNT_W'(1));
            state_next = ST_LAST;
          end else begin
            state_next = ST_SPLIT;
          end
        end
      end
      ST_LAST: begin
        mov_next   = rd;
        idx_next   = '0;
        state_next = ST_SDL;
      end
      // Sift-down: read the left child, then the right one.
      ST_SDL: begin
        if (lchild < (CNT_W + 1)'(cnt)) begin
          ram_raddr  = lchild[IDX_W-1:0];
          state_next = ST_SDLW;
        end else begin
          ram_we     = 1'b1;
          state_next = ST_SPLIT;
        end
      end
      ST_SDLW, ST_SDR: begin
        lft_next = rd;
        if (state == ST_SDLW && rchild < (CNT_W + 1)'(cnt)) begin
          ram_raddr  = rchild[IDX_W-1:0];
          state_next = ST_SDR;
        end else if (best_self) begin
          ram_we     = 1'b1;
          state_next = ST_SPLIT;
        end else begin
          ram_we     = 1'b1;
          ram_wdata  = best;
          idx_next   = best_idx;
          state_next = ST_SDL;
        end
      end
      // Grant the block, and put any tail back into the heap.
      ST_SPLIT: begin
        pay_next   = root.off + ADDR_BITS'(HEADER_BYTES);
        grant_next = gb;
        used_next  = used_sum[BYTE_W] ? '1 : used_sum[BYTE_W-1:0];
        if (peak < used_next) begin
          peak_next = used_next;
        end
        if (split && cnt < CNT_W'(HEAP_ENTRIES)) begin
          mov_next.off   = root.off + ADDR_BITS'(need);
          mov_next.bytes = root.bytes - need[BYTE_W-1:0];
          idx_next       = cnt[IDX_W-1:0];
          cnt_next       = cnt + CNT_W'(1);
          state_next     = ST_SU;
        end else begin
          state_next = ST_DONE;
        end
      end
      // Sift-up: move smaller parents down into the hole.
      ST_SU: begin
        if (idx == '0) begin
          ram_we     = 1'b1;
          state_next = ST_DONE;
        end else begin
          ram_raddr  = parent;
          state_next = ST_SUW;
        end
      end
      ST_SUW: begin
        ram_we = 1'b1;
        if (rd.bytes < mov.bytes) begin
          ram_wdata  = rd;
          idx_next   = parent;
          state_next = ST_SU;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/mhwf_ram.sv
`default_nettype none
module mhwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/mhwf_rem.sv
`default_nettype none
module mhwf_rem import mhwf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [NEED_W-1:0]  dividend,
  input  wire logic [ALIGN_W-1:0] divisor,
  output logic                    done,
  output logic [ALIGN_W-1:0]      rem
);

  localparam int STEP_W = $clog2(NEED_W);

  logic              run;
  logic [STEP_W-1:0] step;
  logic [NEED_W-1:0] quo;
  logic [ALIGN_W-1:0] dvs;
  logic [ALIGN_W:0]  trial;

  // Restoring remainder, one dividend bit per cycle.
  assign trial = {rem, quo[NEED_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(NEED_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (run) begin
      quo <= {quo[NEED_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem <= ALIGN_W'(trial - {1'b0, dvs});
      end else begin
        rem <= ALIGN_W'(trial);
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/mhwf_chk.sv
`default_nettype none
module mhwf_chk import mhwf_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire logic [1:0]        status,
  input wire logic [BYTE_W-1:0] used_bytes,
  input wire logic [BYTE_W-1:0] peak_bytes,
  input wire logic [CNT_W-1:0]  free_blocks
);

  // An accepted item keeps the block busy until its result.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("not busy after accept");

  // A result only appears while an item is in flight, one cycle long.
  a_done: assert property (@(posedge clk) disable iff (rst)
    done |-> busy ##1 !done) else $error("stray or long result");

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> status != 2'd3) else $error("bad status");

  a_peak: assert property (@(posedge clk) disable iff (rst)
    done |-> peak_bytes >= used_bytes) else $error("peak below used");

  a_count: assert property (@(posedge clk) disable iff (rst)
    done |-> free_blocks <= CNT_W'(HEAP_ENTRIES)) else $error("heap overflow");

endmodule

bind max_heap_worst_fit_allocator mhwf_chk u_chk (.*);
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench import mhwf_pkg::*;;

  typedef struct packed {
    logic [1:0]           op;
    logic [BYTE_W-1:0]    req;
    logic [ALIGN_W-1:0]   align;
    logic [ADDR_BITS-1:0] addr;
    logic [BYTE_W-1:0]    fsize;
    logic                 cfg;      // item is a pool_bytes write, not a command
    logic                 drain;    // wait for all results before this item
    logic [6:0]           idle_pct;
  } cmd_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] payload;
    logic [BYTE_W-1:0]    granted;
    logic [BYTE_W-1:0]    used;
    logic [BYTE_W-1:0]    peak;
    logic [CNT_W-1:0]     blocks;
  } answer_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] opcode = '0;
  logic [BYTE_W-1:0] request_size = '0;
  logic [ALIGN_W-1:0] alignment = '0;
  logic [ADDR_BITS-1:0] block_address = '0;
  logic [BYTE_W-1:0] freed_size = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire logic busy, done, pready;
  wire logic [1:0] status;
  wire logic [ADDR_BITS-1:0] payload_address;
  wire logic [BYTE_W-1:0] granted_size, used_bytes, peak_bytes;
  wire logic [CNT_W-1:0] free_blocks;
  wire logic [31:0] prdata;

  max_heap_worst_fit_allocator dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: a copy of the free heap and the byte counters.
  logic [ADDR_BITS-1:0] pm_off [HEAP_ENTRIES];
  logic [BYTE_W-1:0]    pm_bytes [HEAP_ENTRIES];
  int unsigned          pm_count;
  logic [BYTE_W-1:0]    pm_used, pm_peak, pm_pool;

  cmd_t    pending_cmds[$];
  answer_t expected_answers[$];
  int      mismatches = 0;
  int      watchdog = 0;
  bit      stim_done = 1'b0;
  bit      timed_out = 1'b0;

  // Live-block bookkeeping so the stimulus can free real allocations.
  logic [ADDR_BITS-1:0] live_addr[$];
  logic [BYTE_W-1:0]    live_size[$];

  function automatic void heap_swap(int unsigned a, int unsigned b);
    logic [ADDR_BITS-1:0] o;
    logic [BYTE_W-1:0] s;
    o = pm_off[a]; pm_off[a] = pm_off[b]; pm_off[b] = o;
    s = pm_bytes[a]; pm_bytes[a] = pm_bytes[b]; pm_bytes[b] = s;
  endfunction

  function automatic void heap_push(logic [ADDR_BITS-1:0] o, logic [BYTE_W-1:0] s);
    int unsigned i, p;
    if (pm_count >= HEAP_ENTRIES) return;
    pm_off[pm_count] = o;
    pm_bytes[pm_count] = s;
    i = pm_count;
    pm_count++;
    while (i != 0) begin
      p = (i - 1) / 2;
      if (!(pm_bytes[p] < pm_bytes[i])) break;
      heap_swap(p, i);
      i = p;
    end
  endfunction

  function automatic void heap_sink();
    int unsigned i, best, l, r;
    i = 0;
    forever begin
      best = i; l = 2 * i + 1; r = 2 * i + 2;
      if (l < pm_count && pm_bytes[best] < pm_bytes[l]) best = l;
      if (r < pm_count && pm_bytes[best] < pm_bytes[r]) best = r;
      if (best == i) break;
      heap_swap(i, best);
      i = best;
    end
  endfunction

  function automatic void pool_restart();
    pm_off[0] = '0;
    pm_bytes[0] = pm_pool;
    pm_count = 1;
    pm_used = '0;
    pm_peak = '0;
  endfunction

  // Works out the answer for one accepted command and updates the heap copy.
  function automatic answer_t allocator_answer(cmd_t c);
    answer_t a;
    longint unsigned need, al, rem, blk, u;
    logic [ADDR_BITS-1:0] o;
    a = '0;
    case (opcode_t'(c.op))
      OP_ALLOC: begin
        al = (c.align == 0) ? 1 : c.align;
        need = HEADER_BYTES + c.req;
        rem = need % al;
        if (rem != 0) need += al - rem;
        if (pm_count == 0 || need > pm_bytes[0]) begin
          a.status = STAT_NO_FIT;
        end else begin
          o = pm_off[0];
          blk = pm_bytes[0];
          pm_count--;
          if (pm_count != 0) begin
            pm_off[0] = pm_off[pm_count];
            pm_bytes[0] = pm_bytes[pm_count];
            heap_sink();
          end
          if (blk > need + HEADER_BYTES) begin
            heap_push(ADDR_BITS'(o + need), BYTE_W'(blk - need));
            blk = need;
          end
          u = pm_used + blk;
          pm_used = (u > 64'h1FFFFF) ? 21'h1FFFFF : BYTE_W'(u);
          if (pm_peak < pm_used) pm_peak = pm_used;
          a.payload = ADDR_BITS'(o + HEADER_BYTES);
          a.granted = BYTE_W'(blk);
        end
      end
      OP_FREE: begin
        if (pm_count >= HEAP_ENTRIES) begin
          a.status = STAT_FULL;
        end else begin
          heap_push(ADDR_BITS'(c.addr - HEADER_BYTES), c.fsize);
          pm_used = (c.fsize > pm_used) ? '0 : pm_used - c.fsize;
        end
      end
      OP_RESET: pool_restart();
      default: ;
    endcase
    a.used = pm_used;
    a.peak = pm_peak;
    a.blocks = CNT_W'(pm_count);
    return a;
  endfunction

  function automatic cmd_t make_cmd(logic [1:0] op, int unsigned req, int unsigned al,
                                    int unsigned addr, int unsigned fs, int unsigned idle);
    cmd_t c;
    c = '0;
    c.op = op;
    c.req = BYTE_W'(req);
    c.align = ALIGN_W'(al);
    c.addr = ADDR_BITS'(addr);
    c.fsize = BYTE_W'(fs);
    c.idle_pct = 7'(idle);
    return c;
  endfunction

  function automatic cmd_t pool_write(int unsigned bytes);
    cmd_t c;
    c = '0;
    c.cfg = 1'b1;
    c.drain = 1'b1;
    c.fsize = BYTE_W'(bytes);
    return c;
  endfunction

  // Random alignment, mostly powers of two, sometimes zero or any value up to the max.
  function automatic int unsigned rand_align();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 8191);
      1: return 0;
      default: return 1 << $urandom_range(0, 12);
    endcase
  endfunction

  // Builds one random command of a phase; mostly alloc/free of live blocks.
  function automatic cmd_t rand_cmd(int unsigned idle, int unsigned pool);
    int unsigned k, sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2097151)
                                      : $urandom_range(0, pool / 24 + 1);
      return make_cmd(OP_ALLOC, k, rand_align(), 0, 0, idle);
    end else if (sel < 85 && live_addr.size() != 0) begin
      k = $urandom_range(0, live_addr.size() - 1);
      rand_cmd = make_cmd(OP_FREE, 0, 0, live_addr[k], live_size[k], idle);
      live_addr.delete(k);
      live_size.delete(k);
      return rand_cmd;
    end else if (sel < 93) begin
      return make_cmd(OP_FREE, $urandom, $urandom, $urandom, $urandom_range(0, 2097151), idle);
    end else if (sel < 97) begin
      return make_cmd(OP_RESET, $urandom, $urandom, $urandom, $urandom, idle);
    end
    return make_cmd(OP_NONE, $urandom, $urandom, $urandom, $urandom, idle);
  endfunction

  // Stimulus: directed cases, then random phases under several pool sizes.
  initial begin
    int unsigned pools[5];
    int unsigned idles[4];
    cmd_t rc;
    pools = '{65536, 16, 1048576, 2097151, 4096};
    idles = '{0, 56, 0, 37};
    pending_cmds.push_back(make_cmd(OP_ALLOC, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_ALLOC, 100, 4096, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_ALLOC, 2097151, 8191, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_ALLOC, 13, 7, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_FREE, 0, 0, 0, 5000, 0));
    pending_cmds.push_back(make_cmd(OP_FREE, 0, 0, 1048575, 2097151, 0));
    pending_cmds.push_back(make_cmd(OP_FREE, 0, 0, 4, 0, 0));
    pending_cmds.push_back(make_cmd(OP_NONE, 2097151, 8191, 1048575, 2097151, 0));
    pending_cmds.push_back(make_cmd(OP_ALLOC, 65000, 1, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_RESET, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_ALLOC, 65528, 1, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_ALLOC, 0, 1, 0, 0, 0));
    // Fill the heap with small frees to reach the full-heap answer.
    for (int i = 0; i < 66; i++)
      pending_cmds.push_back(make_cmd(OP_FREE, 0, 0, 8 * i + 8, 16, 0));
    pending_cmds.push_back(make_cmd(OP_ALLOC, 4, 8, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_RESET, 0, 0, 0, 0, 0));
    for (int ph = 0; ph < 5; ph++) begin
      pending_cmds.push_back(pool_write(pools[ph]));
      pending_cmds.push_back(make_cmd(OP_RESET, 0, 0, 0, 0, 0));
      live_addr.delete();
      live_size.delete();
      for (int n = 0; n < 352; n++) begin
        rc = rand_cmd(idles[(ph + n / 90) % 4], pools[ph]);
        if (n == 200) rc.drain = 1'b1;
        pending_cmds.push_back(rc);
      end
    end
  end

  // Live-block list follows granted allocations so frees stay well formed.
  function automatic void note_alloc(answer_t a);
    if (a.status == STAT_OK && a.granted != 0 && live_addr.size() < 48) begin
      live_addr.push_back(a.payload);
      live_size.push_back(a.granted);
    end
  endfunction

  // Acceptance tracking at the rising edge.
  bit start_q, accepted_last;
  initial begin
    start_q = 1'b0; accepted_last = 1'b1;
  end

  // Driver: issues commands and APB writes at the falling edge.
  int  cfg_phase = 0;
  int  settle_cnt = 0;
  always @(negedge clk) begin
    cmd_t c;
    if (!rst && !stim_done) begin
      if (pending_cmds.size() == 0) begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end else begin
        c = pending_cmds[0];
        if (c.cfg) begin
          start <= 1'b0;
          if (cfg_phase == 0) begin
            if (expected_answers.size() == 0 && !start_q && !busy) begin
              if (settle_cnt < SETTLE_CYCLES) settle_cnt <= settle_cnt + 1;
              else begin
                psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= 32'(c.fsize);
                cfg_phase <= 1;
              end
            end
          end else if (cfg_phase == 1) begin
            penable <= 1'b1;
            cfg_phase <= 2;
          end else begin
            psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
            pm_pool = c.fsize;
            void'(pending_cmds.pop_front());
            cfg_phase <= 0;
            settle_cnt <= 0;
          end
        end else if (c.drain && (expected_answers.size() != 0 || start_q || busy)) begin
          start <= 1'b0;
        end else if (start && !accepted_last) begin
          // item still waiting for acceptance; hold it
        end else if ($urandom_range(1, 100) <= c.idle_pct) begin
          start <= 1'b0;
        end else begin
          c.drain = 1'b0;
          pending_cmds[0] = c;
          start <= 1'b1;
          opcode <= c.op;
          request_size <= c.req;
          alignment <= c.align;
          block_address <= c.addr;
          freed_size <= c.fsize;
        end
      end
    end
  end

  // Monitor: predicts on acceptance, checks on done.
  always @(posedge clk) begin
    answer_t got, want;
    cmd_t c;
    bit active;
    active = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        c = pending_cmds.pop_front();
        want = allocator_answer(c);
        note_alloc(want);
        expected_answers.push_back(want);
        active = 1'b1;
      end
      if (done) begin
        active = 1'b1;
        got = '{status, payload_address, granted_size, used_bytes, peak_bytes, free_blocks};
        if (expected_answers.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %p", got);
        end else begin
          want = expected_answers.pop_front();
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (psel && penable && pwrite && pready) active = 1'b1;
      watchdog <= active ? 0 : watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) timed_out <= 1'b1;
    end
    accepted_last <= !rst && start && !busy;
    start_q <= start && !busy;
  end

  // Reset, then wait for the end of the stimulus or a timeout.
  initial begin
    pm_pool = POOL_RESET;
    pool_restart();
    repeat (6) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    wait ((stim_done && expected_answers.size() == 0) || timed_out);
    if (!timed_out) repeat (SETTLE_CYCLES) @(posedge clk);
    if (!timed_out && mismatches == 0 && expected_answers.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
